// ----- design/rccd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rccd_pkg: shared types and constants of the run center cross detector
// pixel and coordinate widths, output queue sizing and inter-module structs
// ----------------------------------------------------------------------------
package rccd_pkg;

    localparam int PIXEL_W    = 8;
    localparam int COORD_W    = 9;

    // output queue: absorbs results that are in flight when the receiver stalls
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // per-column run state
    typedef struct packed {
        logic               open;
        logic [COORD_W-1:0] start;
    } col_ent_t;

    // bitmap update and lookup for one pixel
    typedef struct packed {
        logic               wr_en;
        logic [COORD_W-1:0] wr_row;
        logic [COORD_W-1:0] zero_col;
        logic               one_en;
        logic [COORD_W-1:0] one_col;
        logic               look_en;
        logic [COORD_W-1:0] look_row;
        logic [COORD_W-1:0] look_col;
    } bm_req_t;

    // detected crossing
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } point_t;

endpackage
`default_nettype wire

// ----- design/rccd_run_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rccd_run_tracker: row and column run tracking
// input register, row run register, per-column run memory with clearing pass
// ----------------------------------------------------------------------------
module rccd_run_tracker #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [rccd_pkg::PIXEL_W-1:0]  pixel_value,
    input  wire logic [rccd_pkg::COORD_W-1:0]  column,
    input  wire logic [rccd_pkg::COORD_W-1:0]  row,
    output rccd_pkg::bm_req_t                  bm_req,
    output logic                               clearing,
    output logic                               busy
);
    import rccd_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam logic [XW-1:0] LAST_COL = XW'(MAX_WIDTH - 1);

    // input register
    logic               s1_valid_reg;
    logic               s1_fg_reg;
    logic [COORD_W-1:0] s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;

    // row run
    logic               row_open_reg;
    logic               row_open_next;
    logic [COORD_W-1:0] row_start_reg;
    logic [COORD_W-1:0] row_start_next;

    // column run memory
    col_ent_t           col_mem [MAX_WIDTH];
    col_ent_t           col_rd_reg;
    logic               lw_valid_reg;
    logic [XW-1:0]      lw_addr_reg;
    col_ent_t           lw_data_reg;
    logic               col_we;
    logic [XW-1:0]      col_wa;
    col_ent_t           col_wd;

    // clearing pass
    logic               clr_active_reg;
    logic [XW-1:0]      clr_cnt_reg;

    logic               in_range;
    logic               act;
    logic [XW-1:0]      x_idx;
    logic               row_run_live;
    logic               row_close;
    logic [COORD_W:0]   row_sum;
    logic [COORD_W-1:0] row_center;
    col_ent_t           col_cur;
    col_ent_t           col_new;
    logic               col_run_live;
    logic               col_close;
    logic [COORD_W:0]   col_sum;
    logic [COORD_W-1:0] col_center;

    always_comb
    begin
        in_range = (32'(s1_x_reg) < 32'(MAX_WIDTH)) && (32'(s1_y_reg) < 32'(MAX_HEIGHT));
        act      = s1_valid_reg && in_range;
        x_idx    = XW'(s1_x_reg);

        // row run: column zero drops an open run
        row_run_live = row_open_reg && (s1_x_reg != '0);
        row_close    = act && !s1_fg_reg && row_run_live;
        row_sum      = {1'b0, row_start_reg} + {1'b0, s1_x_reg};
        row_center   = row_sum[COORD_W:1];
        row_open_next  = row_open_reg;
        row_start_next = row_start_reg;
        if (act)
        begin
            row_open_next = s1_fg_reg;
            if (s1_fg_reg && !row_run_live)
            begin
                row_start_next = s1_x_reg;
            end
        end

        // column run, forwarding the write made while this read was issued
        col_cur = (lw_valid_reg && (lw_addr_reg == x_idx)) ? lw_data_reg : col_rd_reg;
        col_run_live = col_cur.open && (s1_y_reg != '0);
        col_close    = act && !s1_fg_reg && col_run_live;
        col_sum      = {1'b0, col_cur.start} + {1'b0, s1_y_reg};
        col_center   = col_sum[COORD_W:1];
        col_new.open  = s1_fg_reg;
        col_new.start = (s1_fg_reg && !col_run_live) ? s1_y_reg : col_cur.start;

        col_we = clr_active_reg || act;
        col_wa = clr_active_reg ? clr_cnt_reg : x_idx;
        col_wd = clr_active_reg ? col_ent_t'('0) : col_new;
    end

    always_comb
    begin
        bm_req.wr_en    = act;
        bm_req.wr_row   = s1_y_reg;
        bm_req.zero_col = s1_x_reg;
        bm_req.one_en   = row_close;
        bm_req.one_col  = row_center;
        bm_req.look_en  = col_close;
        bm_req.look_row = col_center;
        bm_req.look_col = s1_x_reg;
    end

    assign clearing = clr_active_reg;
    assign busy     = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            row_open_reg   <= 1'b0;
            lw_valid_reg   <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            row_open_reg <= row_open_next;
            lw_valid_reg <= col_we;
            if (clr_active_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + XW'(1);
                if (clr_cnt_reg == LAST_COL)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_fg_reg <= (pixel_value != '0);
            s1_x_reg  <= column;
            s1_y_reg  <= row;
        end
        row_start_reg <= row_start_next;
        lw_addr_reg   <= col_wa;
        lw_data_reg   <= col_wd;
    end

    // column run memory, registered read at acceptance
    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[col_wa] <= col_wd;
        end
        if (accept)
        begin
            col_rd_reg <= col_mem[XW'(column)];
        end
    end

    a_no_accept_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n) accept |-> !clr_active_reg)
        else $error("transaction accepted during column clearing pass");

    a_clear_ends : assert property (
        @(posedge clk) disable iff (!rst_n)
        (clr_active_reg && (clr_cnt_reg == LAST_COL)) |=> !clr_active_reg)
        else $error("column clearing pass did not end after last column");

endmodule
`default_nettype wire

// ----- design/rccd_center_bitmap.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rccd_center_bitmap: frame bitmap of row run centers
// row-wide words with bit writes, registered lookup and crossing decision
// ----------------------------------------------------------------------------
module rccd_center_bitmap #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rccd_pkg::bm_req_t bm_req,
    output rccd_pkg::point_t       point,
    output logic                   busy
);
    import rccd_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    logic [MAX_WIDTH-1:0] bm_mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] rd_word_reg;

    logic                 s2_valid_reg;
    logic [COORD_W-1:0]   s2_col_reg;
    logic [COORD_W-1:0]   s2_row_reg;
    logic                 s2_same_row_reg;
    logic                 s2_own_one_reg;
    logic                 hit;

    // zero at the pixel, then one at the row center, in one row word
    always_ff @(posedge clk)
    begin
        if (bm_req.wr_en)
        begin
            bm_mem[YW'(bm_req.wr_row)][XW'(bm_req.zero_col)] <= 1'b0;
            if (bm_req.one_en)
            begin
                bm_mem[YW'(bm_req.wr_row)][XW'(bm_req.one_col)] <= 1'b1;
            end
        end
        if (bm_req.look_en)
        begin
            rd_word_reg <= bm_mem[YW'(bm_req.look_row)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= bm_req.look_en;
        end
    end

    // lookup in the pixel's own row sees only this pixel's writes
    always_ff @(posedge clk)
    begin
        s2_col_reg      <= bm_req.look_col;
        s2_row_reg      <= bm_req.look_row;
        s2_same_row_reg <= (bm_req.look_row == bm_req.wr_row);
        s2_own_one_reg  <= bm_req.one_en && (bm_req.one_col == bm_req.look_col);
    end

    always_comb
    begin
        hit = s2_same_row_reg ? s2_own_one_reg : rd_word_reg[XW'(s2_col_reg)];
        point.valid = s2_valid_reg && hit;
        point.x     = s2_col_reg;
        point.y     = s2_row_reg;
    end

    assign busy = s2_valid_reg;

endmodule
`default_nettype wire

// ----- design/rccd_out_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rccd_out_fifo: result queue
// small register queue between the bitmap lookup and the output channel
// ----------------------------------------------------------------------------
module rccd_out_fifo (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rccd_pkg::point_t                  push,
    input  wire logic                              out_stall,
    output logic                                   out_valid,
    output logic [rccd_pkg::COORD_W-1:0]           point_x,
    output logic [rccd_pkg::COORD_W-1:0]           point_y,
    output logic [rccd_pkg::FIFO_CNT_W-1:0]        count
);
    import rccd_pkg::*;

    logic [COORD_W-1:0]    x_mem [FIFO_DEPTH];
    logic [COORD_W-1:0]    y_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;
    logic                  pop;

    always_comb
    begin
        pop      = out_valid && !out_stall;
        cnt_next = cnt_reg;
        if (push.valid && !pop)
        begin
            cnt_next = cnt_reg + FIFO_CNT_W'(1);
        end
        else if (!push.valid && pop)
        begin
            cnt_next = cnt_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            x_mem[wr_ptr_reg] <= push.x;
            y_mem[wr_ptr_reg] <= push.y;
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign point_x   = x_mem[rd_ptr_reg];
    assign point_y   = y_mem[rd_ptr_reg];
    assign count     = cnt_reg;

    a_no_overflow : assert property (
        @(posedge clk) disable iff (!rst_n)
        push.valid |-> ((cnt_reg != FIFO_CNT_W'(FIFO_DEPTH)) || pop))
        else $error("result queue overflow");

    a_count_up : assert property (
        @(posedge clk) disable iff (!rst_n)
        (push.valid && !pop) |=> (cnt_reg == $past(cnt_reg) + FIFO_CNT_W'(1)))
        else $error("result queue count lost a transaction");

endmodule
`default_nettype wire

// ----- design/run_center_cross_detector_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// run_center_cross_detector_unit: run center crossing detector, top level
// finds points where row run centers meet column run centers in a mask
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one mask pixel per transaction in raster order
//   (pixel_value, column, row); a transaction completes when in_valid is
//   high and in_stall is low. row 0 starts a new frame
//   output channel carries one crossing (point_x, point_y) per transaction,
//   in order of column run completion
//   throughput: one pixel per cycle while in_stall is low, set by the single
//   write port of the row-wide center bitmap, which takes both bitmap updates
//   of a pixel. a crossing passes the input register, the bitmap lookup
//   register and the result queue before it is offered
//   reset: the per-column run memory is cleared in a pass over all MAX_WIDTH
//   columns, in_stall stays high during that pass
//   receiver stall: up to four results wait in the result queue; in_stall
//   rises while queued plus in-flight pixels reach the queue depth
// ----------------------------------------------------------------------------
module run_center_cross_detector_unit #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [rccd_pkg::PIXEL_W-1:0]  pixel_value,
    input  wire logic [rccd_pkg::COORD_W-1:0]  column,
    input  wire logic [rccd_pkg::COORD_W-1:0]  row,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [rccd_pkg::COORD_W-1:0]       point_x,
    output logic [rccd_pkg::COORD_W-1:0]       point_y
);
    import rccd_pkg::*;

    logic                  accept;
    logic                  clearing;
    logic                  s1_busy;
    logic                  s2_busy;
    bm_req_t               bm_req;
    point_t                point;
    logic [FIFO_CNT_W-1:0] q_count;
    logic [FIFO_CNT_W-1:0] credit;

    // every pixel in flight may still need a queue slot
    assign credit   = q_count + FIFO_CNT_W'(s1_busy) + FIFO_CNT_W'(s2_busy);
    assign in_stall = clearing || (credit >= FIFO_CNT_W'(FIFO_DEPTH));
    assign accept   = in_valid && !in_stall;

    // input register, row run, column run memory
    rccd_run_tracker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel_value (pixel_value),
        .column      (column),
        .row         (row),
        .bm_req      (bm_req),
        .clearing    (clearing),
        .busy        (s1_busy)
    );

    // center bitmap update and lookup
    rccd_center_bitmap #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_bitmap (
        .clk    (clk),
        .rst_n  (rst_n),
        .bm_req (bm_req),
        .point  (point),
        .busy   (s2_busy)
    );

    // result queue toward the receiver
    rccd_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (point),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .point_x   (point_x),
        .point_y   (point_y),
        .count     (q_count)
    );

    a_credit_bound : assert property (
        @(posedge clk) disable iff (!rst_n) credit <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("more transactions in flight than result queue slots");

endmodule
`default_nettype wire
